// ===== hdl/cba_pkg.sv =====
package cba_pkg;

	localparam int NUM_BLOCKS_DEF = 128;
	localparam int NUM_FILES_DEF  = 32;

	localparam int FUNC_W   = 1;
	localparam int ID_W     = 16;
	localparam int START_W  = 7;
	localparam int LEN_W    = 8;
	localparam int CNT_W    = 8;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 5;

	// blocks checked per cycle during the occupancy scan
	localparam int CHUNK_BITS = 16;

	localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 8'd128;
	localparam logic [FUNC_W-1:0] FUNC_INSERT     = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_DELETE     = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_PAST_END  = 3'd2,
		ST_OCCUPIED  = 3'd3,
		ST_FULL      = 3'd4,
		ST_DELETED   = 3'd5,
		ST_NOT_FOUND = 3'd6
	} cba_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_RANGE,
		S_COMMIT,
		S_REPLY
	} cba_state_t;

	typedef struct packed {
		logic idle;
		logic scan;
		logic range_chk;
		logic commit;
		logic reply;
	} cba_cmd_t;

	typedef struct packed {
		logic in_fire;
		logic is_del;
		logic scan_done;
		logic hit;
		logic past_end;
		logic range_done;
		logic busy;
		logic free_found;
		logic out_free;
	} cba_stat_t;

	function automatic cba_status_t result_code(logic is_del, logic hit, logic past_end,
			logic busy, logic free_found);
		cba_status_t code;
		if (is_del) begin
			code = hit ? ST_DELETED : ST_NOT_FOUND;
		end else if (hit) begin
			code = ST_DUPLICATE;
		end else if (past_end) begin
			code = ST_PAST_END;
		end else if (busy) begin
			code = ST_OCCUPIED;
		end else if (!free_found) begin
			code = ST_FULL;
		end else begin
			code = ST_INSERTED;
		end
		return code;
	endfunction

endpackage

// ===== hdl/cba_if.sv =====
interface cba_in_if;
	logic                         valid;
	logic                         ready;
	logic [cba_pkg::FUNC_W-1:0]   func;
	logic [cba_pkg::ID_W-1:0]     file_id;
	logic [cba_pkg::START_W-1:0]  start_block;
	logic [cba_pkg::LEN_W-1:0]    block_len;

	modport source (output valid, func, file_id, start_block, block_len, input ready);
	modport sink (input valid, func, file_id, start_block, block_len, output ready);
endinterface

interface cba_out_if;
	logic                          valid;
	logic                          ready;
	logic [cba_pkg::STATUS_W-1:0]  status;
	logic [cba_pkg::INDEX_W-1:0]   entry_index;

	modport source (output valid, status, entry_index, input ready);
	modport sink (input valid, status, entry_index, output ready);
endinterface

// ===== hdl/cba_ram.sv =====
module cba_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/cba_ctrl.sv =====
module cba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  cba_pkg::cba_stat_t stat,
	output cba_pkg::cba_cmd_t  cmd
);

	cba_pkg::cba_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cba_pkg::S_IDLE: begin
				if (stat.in_fire) state_d = cba_pkg::S_SCAN;
			end
			cba_pkg::S_SCAN: begin
				if (stat.scan_done) begin
					if (stat.is_del) begin
						state_d = stat.hit ? cba_pkg::S_COMMIT : cba_pkg::S_REPLY;
					end else if (stat.hit || stat.past_end) begin
						state_d = cba_pkg::S_REPLY;
					end else begin
						state_d = cba_pkg::S_RANGE;
					end
				end
			end
			cba_pkg::S_RANGE: begin
				if (stat.range_done) begin
					if (stat.busy || !stat.free_found) begin
						state_d = cba_pkg::S_REPLY;
					end else begin
						state_d = cba_pkg::S_COMMIT;
					end
				end
			end
			cba_pkg::S_COMMIT: begin
				state_d = cba_pkg::S_REPLY;
			end
			cba_pkg::S_REPLY: begin
				if (stat.out_free) state_d = cba_pkg::S_IDLE;
			end
			default: begin
				state_d = cba_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			cba_pkg::S_IDLE:   cmd.idle      = 1'b1;
			cba_pkg::S_SCAN:   cmd.scan      = 1'b1;
			cba_pkg::S_RANGE:  cmd.range_chk = 1'b1;
			cba_pkg::S_COMMIT: cmd.commit    = 1'b1;
			cba_pkg::S_REPLY:  cmd.reply     = 1'b1;
			default:           cmd           = '0;
		endcase
	end

endmodule

// ===== hdl/cba_datapath.sv =====
module cba_datapath #(
	parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF,
	parameter int NUM_FILES  = cba_pkg::NUM_FILES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cba_pkg::cba_cmd_t          cmd,
	output cba_pkg::cba_stat_t         stat,
	input  logic                       cfg_we,
	input  logic [cba_pkg::CNT_W-1:0]  cfg_wdata,
	cba_in_if.sink                     req,
	cba_out_if.source                  rsp
);

	localparam int FW         = $clog2(NUM_FILES);
	// a range never reaches past block 254, so higher blocks need no map bit
	localparam int MAP_BLOCKS = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
	localparam int CHUNK      = cba_pkg::CHUNK_BITS;
	localparam int NUM_CHUNKS = (MAP_BLOCKS + CHUNK - 1) / CHUNK;
	localparam int MAP_BITS   = NUM_CHUNKS * CHUNK;
	localparam int CW         = $clog2(NUM_CHUNKS + 1);
	localparam int CIW        = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int ID_W       = cba_pkg::ID_W;
	localparam int START_W    = cba_pkg::START_W;
	localparam int LEN_W      = cba_pkg::LEN_W;
	localparam int EW         = ID_W + START_W + LEN_W;
	localparam int LIM_CAP    = (NUM_BLOCKS < 255) ? NUM_BLOCKS : 255;
	localparam int IDX_W      = cba_pkg::INDEX_W;

	// command word
	logic [cba_pkg::FUNC_W-1:0] func_q;
	logic [ID_W-1:0]            key_q;
	logic [START_W-1:0]         start_q;
	logic [LEN_W-1:0]           len_q;

	logic [cba_pkg::CNT_W-1:0]  bcount_q;
	logic [MAP_BITS-1:0]        map_q;
	logic [NUM_FILES-1:0]       valid_q;

	// table search
	logic [FW:0]                rd_q;
	logic                       scan_vld_s1;
	logic                       valid_s1;
	logic [FW-1:0]              idx_s1;
	logic                       hit_q;
	logic [FW-1:0]              hit_idx_q;
	logic [START_W-1:0]         hit_start_q;
	logic [LEN_W-1:0]           hit_len_q;
	logic                       free_q;
	logic [FW-1:0]              free_idx_q;

	// occupancy check
	logic [CW-1:0]              chunk_q;
	logic                       busy_q;

	logic                       out_valid_q;
	logic [cba_pkg::STATUS_W-1:0] out_status_q;
	logic [IDX_W-1:0]           out_index_q;

	logic [EW-1:0]              rdata;
	logic [ID_W-1:0]            rd_key;
	logic [START_W-1:0]         rd_start;
	logic [LEN_W-1:0]           rd_len;
	logic                       in_fire;
	logic                       is_del;
	logic                       scan_more;
	logic                       out_free;
	logic [cba_pkg::CNT_W-1:0]  limit;
	logic                       past_end;
	logic [START_W-1:0]         rng_lo;
	logic [LEN_W-1:0]           rng_len;
	logic [8:0]                 rng_hi;
	logic [MAP_BITS-1:0]        mask;
	logic [CIW-1:0]             chunk_idx;
	logic [CHUNK-1:0]           chunk_hits;
	cba_pkg::cba_status_t       code;
	logic [FW-1:0]              res_idx;
	logic [FW+IDX_W-1:0]        res_idx_ext;

	cba_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_FILES)
	) u_table (
		.clk   (clk),
		.we    (cmd.commit && !is_del),
		.waddr (free_idx_q),
		.wdata ({key_q, start_q, len_q}),
		.raddr (rd_q[FW-1:0]),
		.rdata (rdata)
	);

	assign rd_key   = rdata[EW-1 -: ID_W];
	assign rd_start = rdata[LEN_W +: START_W];
	assign rd_len   = rdata[LEN_W-1:0];

	assign in_fire   = req.valid && cmd.idle;
	assign req.ready = cmd.idle;
	assign is_del    = (func_q == cba_pkg::FUNC_DELETE);
	assign scan_more = (rd_q != (FW+1)'(NUM_FILES));
	assign out_free  = !out_valid_q || rsp.ready;

	// block count saturated to NUM_BLOCKS, and to 255 at most
	assign limit    = (bcount_q > 8'(LIM_CAP)) ? 8'(LIM_CAP) : bcount_q;
	assign past_end = (9'(start_q) + 9'(len_q)) > 9'(limit);

	// delete frees the stored range, insert claims the requested one
	assign rng_lo  = is_del ? hit_start_q : start_q;
	assign rng_len = is_del ? hit_len_q : len_q;
	assign rng_hi  = 9'(rng_lo) + 9'(rng_len);

	always_comb begin
		for (int b = 0; b < MAP_BITS; b++) begin
			mask[b] = (9'(b) >= 9'(rng_lo)) && (9'(b) < rng_hi);
		end
	end

	assign chunk_idx  = chunk_q[CIW-1:0];
	assign chunk_hits = map_q[chunk_idx*CHUNK +: CHUNK] & mask[chunk_idx*CHUNK +: CHUNK];

	assign code        = cba_pkg::result_code(is_del, hit_q, past_end, busy_q, free_q);
	assign res_idx     = (code == cba_pkg::ST_DELETED) ? hit_idx_q :
	                     (code == cba_pkg::ST_INSERTED) ? free_idx_q : '0;
	assign res_idx_ext = (FW+IDX_W)'(res_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcount_q    <= cba_pkg::BLOCK_COUNT_RST;
			map_q       <= '0;
			valid_q     <= '0;
			rd_q        <= '0;
			scan_vld_s1 <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			chunk_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) bcount_q <= cfg_wdata;

			if (in_fire) begin
				rd_q        <= '0;
				scan_vld_s1 <= 1'b0;
				hit_q       <= 1'b0;
				free_q      <= 1'b0;
				chunk_q     <= '0;
				busy_q      <= 1'b0;
			end

			if (cmd.scan) begin
				if (scan_more) rd_q <= rd_q + (FW+1)'(1);
				scan_vld_s1 <= scan_more;
				if (scan_vld_s1 && valid_s1 && (rd_key == key_q)) hit_q <= 1'b1;
				if (scan_vld_s1 && !valid_s1) free_q <= 1'b1;
			end

			if (cmd.range_chk && (chunk_q != CW'(NUM_CHUNKS))) begin
				chunk_q <= chunk_q + CW'(1);
				if (|chunk_hits) busy_q <= 1'b1;
			end

			if (cmd.commit) begin
				if (is_del) begin
					map_q              <= map_q & ~mask;
					valid_q[hit_idx_q] <= 1'b0;
				end else begin
					map_q               <= map_q | mask;
					valid_q[free_idx_q] <= 1'b1;
				end
			end

			if (cmd.reply && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q  <= req.func;
			key_q   <= req.file_id;
			start_q <= req.start_block;
			len_q   <= req.block_len;
		end
		valid_s1 <= valid_q[rd_q[FW-1:0]];
		idx_s1   <= rd_q[FW-1:0];
		// keep the first matching entry and the first free entry
		if (cmd.scan && scan_vld_s1 && valid_s1 && (rd_key == key_q) && !hit_q) begin
			hit_idx_q   <= idx_s1;
			hit_start_q <= rd_start;
			hit_len_q   <= rd_len;
		end
		if (cmd.scan && scan_vld_s1 && !valid_s1 && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.reply && out_free) begin
			out_status_q <= code;
			out_index_q  <= res_idx_ext[IDX_W-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_index = out_index_q;

	always_comb begin
		stat            = '0;
		stat.in_fire    = in_fire;
		stat.is_del     = is_del;
		stat.scan_done  = !scan_more && !scan_vld_s1;
		stat.hit        = hit_q;
		stat.past_end   = past_end;
		stat.range_done = (chunk_q == CW'(NUM_CHUNKS));
		stat.busy       = busy_q;
		stat.free_found = free_q;
		stat.out_free   = out_free;
	end

endmodule

// ===== hdl/contiguous_block_allocator_core.sv =====
// contiguous block allocator
// req channel carries one command word: func (insert or delete), file_id, and for an
// insert start_block and block_len. rsp channel returns one word per command with
// status and entry_index (entry written or freed, zero when refused).
// cfg_we/cfg_wdata write block_count, the number of usable blocks; write it only
// while no command is in flight.
// one command is processed at a time; req.ready is high while the block is idle.
// the file table is searched serially, one entry per cycle from its memory, and the
// block map is checked CHUNK_BITS blocks per cycle. an insert is searched, checked
// against the map and then written; an insert refused by the map check or a full table
// skips the write; a delete that frees an entry skips the map check; a duplicate id, a
// range past the block count or a missing id is answered straight after the search.
// the next command can be accepted in the cycle after the result is registered.
// a finished word sits in the output register; the next command can be accepted
// while it waits, but its result is held until rsp.ready takes the previous word.
// reset clears the block map and the table valid bits at once (every block free,
// table empty) and sets block_count to 128; no clearing pass is needed.
module contiguous_block_allocator_core #(
	parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF,
	parameter int NUM_FILES  = cba_pkg::NUM_FILES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cba_pkg::CNT_W-1:0]  cfg_wdata,
	cba_in_if.sink                     req,
	cba_out_if.source                  rsp
);

	cba_pkg::cba_cmd_t  cmd;
	cba_pkg::cba_stat_t stat;

	cba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	cba_datapath #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.NUM_FILES (NUM_FILES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({cmd.idle, cmd.scan, cmd.range_chk, cmd.commit, cmd.reply}))
		else $error("controller phase not one-hot");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> cmd.scan)
		else $error("accepted word did not start table search");

	a_rsp_from_reply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.reply))
		else $error("result word appeared outside reply phase");

	a_commit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (stat.is_del ? stat.hit
			: (stat.free_found && !stat.busy && !stat.past_end && !stat.hit)))
		else $error("table or map written for a refused command");

endmodule

// ===== verif/contiguous_block_allocator_checker.sv =====
module contiguous_block_allocator_checker #(
	parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF,
	parameter int NUM_FILES  = cba_pkg::NUM_FILES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cba_pkg::CNT_W-1:0]  cfg_wdata,
	cba_in_if                          req,
	cba_out_if                         rsp,
	output int                         outstanding,
	output int                         failures
);
	import cba_pkg::*;

	typedef struct {
		cba_status_t             status;
		logic [INDEX_W-1:0]      slot;
	} reply_t;

	logic                block_busy [NUM_BLOCKS];
	logic                slot_live [NUM_FILES];
	logic [ID_W-1:0]     slot_id [NUM_FILES];
	logic [START_W-1:0]  slot_first [NUM_FILES];
	logic [LEN_W-1:0]    slot_len [NUM_FILES];
	logic [CNT_W-1:0]    usable_blocks;

	reply_t awaited_replies[$];
	int     mismatch_count;

	// runs one command against the shadow map and table, returns the reply word
	function automatic reply_t apply_command(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id,
			logic [START_W-1:0] first, logic [LEN_W-1:0] len);
		reply_t r;
		int     owner;
		int     free_slot;
		int     limit;
		int     stop;
		bit     clash;
		r.status  = ST_NOT_FOUND;
		r.slot    = '0;
		owner     = -1;
		free_slot = -1;
		clash     = 1'b0;
		for (int k = 0; k < NUM_FILES; k++) begin
			if (slot_live[k] && slot_id[k] == id && owner < 0)
				owner = k;
			if (!slot_live[k] && free_slot < 0)
				free_slot = k;
		end
		limit = (usable_blocks > NUM_BLOCKS) ? NUM_BLOCKS : usable_blocks;
		if (op == FUNC_DELETE) begin
			if (owner >= 0) begin
				// stored range is freed whatever the block count is now
				stop = int'(slot_first[owner]) + int'(slot_len[owner]);
				for (int b = int'(slot_first[owner]); b < stop; b++)
					if (b < NUM_BLOCKS)
						block_busy[b] = 1'b0;
				slot_live[owner] = 1'b0;
				r.status = ST_DELETED;
				r.slot   = INDEX_W'(owner);
			end
		end else if (owner >= 0) begin
			r.status = ST_DUPLICATE;
		end else begin
			stop = int'(first) + int'(len);
			if (stop > limit) begin
				r.status = ST_PAST_END;
			end else begin
				for (int b = int'(first); b < stop; b++)
					if (b < NUM_BLOCKS && block_busy[b])
						clash = 1'b1;
				if (clash) begin
					r.status = ST_OCCUPIED;
				end else if (free_slot < 0) begin
					r.status = ST_FULL;
				end else begin
					for (int b = int'(first); b < stop; b++)
						block_busy[b] = 1'b1;
					slot_live[free_slot]  = 1'b1;
					slot_id[free_slot]    = id;
					slot_first[free_slot] = first;
					slot_len[free_slot]   = len;
					r.status = ST_INSERTED;
					r.slot   = INDEX_W'(free_slot);
				end
			end
		end
		return r;
	endfunction

	function automatic void flag_error(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%t rsp mismatch: %s", $realtime, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int b = 0; b < NUM_BLOCKS; b++)
				block_busy[b] = 1'b0;
			for (int k = 0; k < NUM_FILES; k++)
				slot_live[k] = 1'b0;
			usable_blocks = BLOCK_COUNT_RST;
			awaited_replies.delete();
			mismatch_count = 0;
			outstanding <= 0;
			failures    <= 0;
		end else begin
			// the reply leaving now belongs to an older command, so check before predicting
			if (rsp.valid && rsp.ready) begin
				if (awaited_replies.size() == 0) begin
					flag_error($sformatf("status %0d index %0d with no command outstanding",
						rsp.status, rsp.entry_index));
				end else begin
					want = awaited_replies.pop_front();
					if (rsp.status !== want.status || rsp.entry_index !== want.slot)
						flag_error($sformatf("expected status %0d index %0d, got status %0d index %0d",
							want.status, want.slot, rsp.status, rsp.entry_index));
				end
			end
			if (cfg_we)
				usable_blocks = cfg_wdata;
			if (req.valid && req.ready)
				awaited_replies.push_back(apply_command(req.func, req.file_id,
					req.start_block, req.block_len));
			outstanding <= awaited_replies.size();
			failures    <= mismatch_count;
		end
	end

endmodule

// ===== verif/contiguous_block_allocator_core_test.sv =====
module contiguous_block_allocator_core_test;
	import cba_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASE_ITEMS   = 150;
	localparam int POOL_SIZE     = 48;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CNT_W-1:0]  cfg_wdata;
	int                outstanding;
	int                failures;
	int                cycle_count = 0;

	bit                steady;
	int                cur_limit;
	logic [ID_W-1:0]   id_pool [POOL_SIZE];

	int                replies_taken = 0;
	int                hold_left = 0;
	int                stall_left = 0;

	int phase_counts [9] = '{128, 1, 40, 128, 0, 255, 7, 128, 96};
	int insert_pcts  [9] = '{55, 50, 85, 40, 50, 90, 50, 35, 60};

	cba_in_if  cmd_ch ();
	cba_out_if reply_ch ();

	contiguous_block_allocator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (cmd_ch),
		.rsp       (reply_ch)
	);

	contiguous_block_allocator_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (cmd_ch),
		.rsp         (reply_ch),
		.outstanding (outstanding),
		.failures    (failures)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("contiguous_block_allocator_core_test: FAIL");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	// receiver: random stalls, plus two long hold-offs that back the block up
	always @(posedge clk) begin
		if (reply_ch.valid && reply_ch.ready) begin
			replies_taken++;
			if (replies_taken == 150 || replies_taken == 800)
				hold_left = 600;
			else if (!steady)
				stall_left = pick_gap();
		end else if (!steady && reply_ch.ready && $urandom_range(0, 49) == 0) begin
			stall_left = pick_gap();
		end
		if (hold_left > 0) begin
			hold_left--;
			reply_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			reply_ch.ready <= 1'b0;
		end else begin
			reply_ch.ready <= 1'b1;
		end
	end

	task automatic issue(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id,
			logic [START_W-1:0] first, logic [LEN_W-1:0] len);
		int gap;
		cmd_ch.valid       <= 1'b1;
		cmd_ch.func        <= op;
		cmd_ch.file_id     <= id;
		cmd_ch.start_block <= first;
		cmd_ch.block_len   <= len;
		do @(posedge clk); while (!cmd_ch.ready);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// only touch the register once every reply is back
	task automatic set_block_count(logic [CNT_W-1:0] value);
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_limit = int'(value);
	endtask

	task automatic random_word(int insert_pct);
		logic [FUNC_W-1:0]  op;
		logic [ID_W-1:0]    id;
		logic [START_W-1:0] first;
		logic [LEN_W-1:0]   len;
		int                 r;
		int                 span;
		op = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_DELETE;
		if ($urandom_range(0, 99) < 90)
			id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			id = ID_W'($urandom_range(0, 65535));
		span = (cur_limit > 127) ? 127 : cur_limit;
		if ($urandom_range(0, 99) < 80)
			first = START_W'($urandom_range(0, span));
		else
			first = START_W'($urandom_range(0, 127));
		r = $urandom_range(0, 99);
		if (r < 10)
			len = '0;
		else if (insert_pct >= 85)
			len = LEN_W'($urandom_range(1, 3));
		else if (r < 75)
			len = LEN_W'($urandom_range(1, 8));
		else if (r < 93)
			len = LEN_W'($urandom_range(9, 40));
		else if (r < 99)
			len = LEN_W'($urandom_range(41, 128));
		else
			len = LEN_W'($urandom_range(129, 255));
		issue(op, id, first, len);
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		cmd_ch.valid       <= 1'b0;
		cmd_ch.func        <= FUNC_INSERT;
		cmd_ch.file_id     <= '0;
		cmd_ch.start_block <= '0;
		cmd_ch.block_len   <= '0;
		steady             <= 1'b0;
		cur_limit = BLOCK_COUNT_RST;
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hffff;
		for (int j = 2; j < POOL_SIZE; j++)
			id_pool[j] = ID_W'($urandom_range(0, 65535));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_block_count(8'd128);
		issue(FUNC_INSERT, 16'h0000, 7'd0, 8'd0);      // zero length still takes an entry
		issue(FUNC_INSERT, 16'hffff, 7'd127, 8'd1);
		issue(FUNC_INSERT, 16'hffff, 7'd0, 8'd1);      // duplicate wins over everything
		issue(FUNC_INSERT, 16'h1234, 7'd127, 8'd2);
		issue(FUNC_INSERT, 16'h1234, 7'd0, 8'd128);    // fits the count, hits block 127
		issue(FUNC_INSERT, 16'h1234, 7'd127, 8'd255);
		issue(FUNC_DELETE, 16'habcd, 7'd0, 8'd0);
		issue(FUNC_DELETE, 16'hffff, 7'd0, 8'd0);
		issue(FUNC_INSERT, 16'h1234, 7'd0, 8'd128);    // whole map, reuses the freed entry
		issue(FUNC_INSERT, 16'h5555, 7'd64, 8'd1);
		issue(FUNC_INSERT, 16'h5555, 7'd127, 8'd0);    // zero length never clashes
		issue(FUNC_DELETE, 16'h1234, 7'd0, 8'd0);
		issue(FUNC_INSERT, 16'haaaa, 7'h55, 8'h2a);
		issue(FUNC_DELETE, 16'h0000, 7'd0, 8'd0);
		issue(FUNC_DELETE, 16'h5555, 7'd0, 8'd0);
		issue(FUNC_DELETE, 16'haaaa, 7'd0, 8'd0);
		set_block_count(8'd0);
		issue(FUNC_INSERT, 16'h0007, 7'd0, 8'd0);
		issue(FUNC_INSERT, 16'h0008, 7'd1, 8'd0);
		issue(FUNC_INSERT, 16'h0009, 7'd0, 8'd1);
		issue(FUNC_DELETE, 16'h0007, 7'd0, 8'd0);
		set_block_count(8'd255);                       // saturates to the map size
		issue(FUNC_INSERT, 16'h000a, 7'd127, 8'd1);
		issue(FUNC_INSERT, 16'h000b, 7'd100, 8'd29);
		set_block_count(8'd1);
		issue(FUNC_INSERT, 16'h000c, 7'd0, 8'd1);
		issue(FUNC_INSERT, 16'h000d, 7'd1, 8'd0);
		issue(FUNC_INSERT, 16'h000e, 7'd1, 8'd1);
		issue(FUNC_DELETE, 16'h000a, 7'd0, 8'd0);      // range beyond the lowered count

		for (int p = 0; p < 9; p++) begin
			set_block_count(CNT_W'(phase_counts[p]));
			steady <= (p == 3 || p == 7);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_word(insert_pcts[p]);
		end

		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (60) @(posedge clk);
		if (failures == 0)
			$display("contiguous_block_allocator_core_test: PASS");
		else
			$display("contiguous_block_allocator_core_test: FAIL");
		$finish;
	end

endmodule
